### sv/twd_pkg.sv
package twd_pkg;

  localparam int MAX_HITS_DEFAULT = 256;

  localparam int CODE_W  = 4;
  localparam int KIND_W  = 3;
  localparam int TICKS_W = 48;
  localparam int CFG_IDX_W = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BAD_HEADER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HIT        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HIT_DROP   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRIG_NUM   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TRIG_TIME  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODE_EVENT_HEADER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TRIGGER_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_DEVICE_ID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TDC_HIT      = 3'd3;

  localparam logic [CODE_W-1:0] RESET_CODE_EVENT_HEADER = 4'd2;
  localparam logic [CODE_W-1:0] RESET_CODE_TRIGGER_TIME = 4'd3;
  localparam logic [CODE_W-1:0] RESET_CODE_DEVICE_ID    = 4'd7;
  localparam logic [CODE_W-1:0] RESET_CODE_TDC_HIT      = 4'd8;

  typedef struct packed {
    logic [CODE_W-1:0] event_header;
    logic [CODE_W-1:0] trigger_time;
    logic [CODE_W-1:0] device_id;
    logic [CODE_W-1:0] tdc_hit;
  } codes_t;

  typedef struct packed {
    logic [CODE_W-1:0]  current_type;
    logic               type_known;
    logic [1:0]         cont_idx;
    logic [TICKS_W-1:0] ticks;
    logic [4:0]         fiber;
    logic [4:0]         slot;
    logic               event_valid;
  } dec_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [7:0]         hit_channel;
    logic               hit_edge;
    logic [4:0]         hit_fiber;
    logic [4:0]         hit_slot;
    logic [14:0]        hit_time;
    logic [8:0]         hit_index;
    logic [21:0]        trigger_number;
    logic [TICKS_W-1:0] trigger_ticks;
  } result_t;

endpackage

### sv/twd_decode.sv
module twd_decode #(
  parameter int MAX_HITS = twd_pkg::MAX_HITS_DEFAULT,
  localparam int CNT_W = $clog2(MAX_HITS + 1)
) (
  input  logic [31:0]         word,
  input  logic                first_word,
  input  twd_pkg::codes_t     codes,
  input  twd_pkg::dec_state_t state,
  input  logic [CNT_W-1:0]    hits,
  output twd_pkg::dec_state_t state_next,
  output logic [CNT_W-1:0]    hits_next,
  output twd_pkg::result_t    result
);
  import twd_pkg::*;

  logic [CODE_W-1:0] code;
  logic              typed;
  logic [CNT_W+8:0]  hits_wide;

  assign code      = word[30:27];
  assign typed     = word[31];
  assign hits_wide = {9'd0, hits};

  always_comb begin
    state_next = state;
    hits_next  = hits;
    result     = '0;
    result.kind = KIND_NONE;

    if (first_word) begin
      state_next.current_type = '0;
      state_next.type_known   = 1'b0;
      state_next.cont_idx     = 2'd0;
      state_next.ticks        = '0;
      hits_next               = '0;
      if (typed && code == codes.event_header) begin
        state_next.event_valid = 1'b1;
        state_next.slot        = word[26:22];
      end else begin
        state_next.event_valid = 1'b0;
        result.kind            = KIND_BAD_HEADER;
      end
    end else if (state.event_valid) begin
      if (typed) begin
        state_next.current_type = code;
        state_next.type_known   = 1'b1;
        state_next.cont_idx     = 2'd0;
      end else if (state.cont_idx < 2'd2) begin
        state_next.cont_idx = state.cont_idx + 2'd1;
      end

      if (state_next.type_known) begin
        // first match wins when codes overlap
        if (state_next.current_type == codes.event_header) begin
          result.kind           = KIND_TRIG_NUM;
          result.trigger_number = word[21:0];
        end else if (state_next.current_type == codes.trigger_time) begin
          if (state_next.cont_idx == 2'd0) begin
            state_next.ticks = {24'd0, word[23:0]};
          end else if (state_next.cont_idx == 2'd1) begin
            state_next.ticks = state.ticks | {word[23:0], 24'd0};
          end
          result.kind          = KIND_TRIG_TIME;
          result.trigger_ticks = state_next.ticks;
        end else if (state_next.current_type == codes.device_id) begin
          state_next.fiber = word[26:22];
        end else if (state_next.current_type == codes.tdc_hit) begin
          result.hit_channel = word[23:16];
          result.hit_edge    = word[26];
          result.hit_fiber   = state.fiber;
          result.hit_slot    = state.slot;
          result.hit_time    = word[14:0];
          result.hit_index   = hits_wide[8:0];
          if (hits < CNT_W'(MAX_HITS)) begin
            result.kind = KIND_HIT;
            hits_next   = hits + CNT_W'(1);
          end else begin
            result.kind = KIND_HIT_DROP;
          end
        end
      end
    end
  end

endmodule

### sv/tagged_word_tdc_decoder.sv
// channel  handshake            payload
// in       in_valid/in_ready    word, first_word
// out      out_valid/out_ready  kind, hit_*, trigger_number, trigger_ticks
// cfg      cfg_we               cfg_index, cfg_data (4-bit type codes)
//
// one beat in per cycle unless the out side stalls: decode is a single pass
// from the input word and the event state into the result register
// in_ready stays high while the result register is empty or being taken
// rst is synchronous and restores default codes and clears the event state
// a stalled out beat holds the result and blocks only new input
module tagged_word_tdc_decoder #(
  parameter int MAX_HITS = twd_pkg::MAX_HITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     word,
  input  logic                            first_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [twd_pkg::KIND_W-1:0]      kind,
  output logic [7:0]                      hit_channel,
  output logic                            hit_edge,
  output logic [4:0]                      hit_fiber,
  output logic [4:0]                      hit_slot,
  output logic [14:0]                     hit_time,
  output logic [8:0]                      hit_index,
  output logic [21:0]                     trigger_number,
  output logic [twd_pkg::TICKS_W-1:0]     trigger_ticks,
  input  logic                            cfg_we,
  input  logic [twd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twd_pkg::CODE_W-1:0]      cfg_data
);
  import twd_pkg::*;

  localparam int CNT_W = $clog2(MAX_HITS + 1);

  codes_t            codes;
  dec_state_t        state;
  dec_state_t        state_next;
  logic [CNT_W-1:0]  hits;
  logic [CNT_W-1:0]  hits_next;
  result_t           res_next;
  result_t           res;
  logic              accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  twd_decode #(
    .MAX_HITS(MAX_HITS)
  ) u_decode (
    .word       (word),
    .first_word (first_word),
    .codes      (codes),
    .state      (state),
    .hits       (hits),
    .state_next (state_next),
    .hits_next  (hits_next),
    .result     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.event_header <= RESET_CODE_EVENT_HEADER;
      codes.trigger_time <= RESET_CODE_TRIGGER_TIME;
      codes.device_id    <= RESET_CODE_DEVICE_ID;
      codes.tdc_hit      <= RESET_CODE_TDC_HIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_EVENT_HEADER: codes.event_header <= cfg_data;
        REG_CODE_TRIGGER_TIME: codes.trigger_time <= cfg_data;
        REG_CODE_DEVICE_ID:    codes.device_id    <= cfg_data;
        REG_CODE_TDC_HIT:      codes.tdc_hit      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      hits      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        hits      <= hits_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign kind           = res.kind;
  assign hit_channel    = res.hit_channel;
  assign hit_edge       = res.hit_edge;
  assign hit_fiber      = res.hit_fiber;
  assign hit_slot       = res.hit_slot;
  assign hit_time       = res.hit_time;
  assign hit_index      = res.hit_index;
  assign trigger_number = res.trigger_number;
  assign trigger_ticks  = res.trigger_ticks;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_first_clears_hits: assert property (@(posedge clk) disable iff (rst)
    accept && first_word |=> hits == '0)
    else $error("hit count not cleared on first word");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    hits <= CNT_W'(MAX_HITS))
    else $error("hit count beyond capacity");

  a_quiet_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NONE || kind == KIND_BAD_HEADER)
      |-> trigger_ticks == '0 && trigger_number == '0 && hit_index == '0)
    else $error("unused fields not zero");

  a_hit_counts_up: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.kind == KIND_HIT |=> hits == $past(hits) + CNT_W'(1))
    else $error("hit did not advance count");

endmodule

### test/tdc_decode_checker.sv
module tdc_decode_checker #(
  parameter int MAX_HITS = twd_pkg::MAX_HITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [31:0]                     word,
  input  logic                            first_word,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [twd_pkg::KIND_W-1:0]      kind,
  input  logic [7:0]                      hit_channel,
  input  logic                            hit_edge,
  input  logic [4:0]                      hit_fiber,
  input  logic [4:0]                      hit_slot,
  input  logic [14:0]                     hit_time,
  input  logic [8:0]                      hit_index,
  input  logic [21:0]                     trigger_number,
  input  logic [twd_pkg::TICKS_W-1:0]     trigger_ticks,
  input  logic                            cfg_we,
  input  logic [twd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twd_pkg::CODE_W-1:0]      cfg_data,
  output int                              mismatches,
  output int                              pending
);
  import twd_pkg::*;

  codes_t             codes;
  logic [CODE_W-1:0]  cur_type;
  logic               type_known;
  logic [1:0]         cont_idx;
  logic [TICKS_W-1:0] ticks;
  logic [4:0]         fiber;
  logic [4:0]         slot;
  int unsigned        hit_count;
  logic               event_open;
  result_t            expected_results[$];

  function automatic result_t decode_word(input logic [31:0] w, input logic first);
    result_t           r;
    logic [CODE_W-1:0] code;
    logic              typed;
    r = '0;
    r.kind = KIND_NONE;
    code = w[30:27];
    typed = w[31];
    if (first) begin
      cur_type = '0;
      type_known = 1'b0;
      cont_idx = 2'd0;
      ticks = '0;
      hit_count = 0;
      if (typed && code == codes.event_header) begin
        event_open = 1'b1;
        slot = w[26:22];
      end else begin
        event_open = 1'b0;
        r.kind = KIND_BAD_HEADER;
      end
      return r;
    end
    if (!event_open) return r;
    if (typed) begin
      cur_type = code;
      type_known = 1'b1;
      cont_idx = 2'd0;
    end else if (cont_idx < 2'd2) begin
      cont_idx = cont_idx + 2'd1;
    end
    // continuation words before any type word fall through here
    if (!type_known) return r;
    if (cur_type == codes.event_header) begin
      r.kind = KIND_TRIG_NUM;
      r.trigger_number = w[21:0];
    end else if (cur_type == codes.trigger_time) begin
      if (cont_idx == 2'd0) ticks = {24'd0, w[23:0]};
      else if (cont_idx == 2'd1) ticks[47:24] = ticks[47:24] | w[23:0];
      r.kind = KIND_TRIG_TIME;
      r.trigger_ticks = ticks;
    end else if (cur_type == codes.device_id) begin
      fiber = w[26:22];
    end else if (cur_type == codes.tdc_hit) begin
      r.hit_channel = w[23:16];
      r.hit_edge = w[26];
      r.hit_fiber = fiber;
      r.hit_slot = slot;
      r.hit_time = w[14:0];
      r.hit_index = 9'(hit_count);
      if (hit_count < MAX_HITS) begin
        r.kind = KIND_HIT;
        hit_count++;
      end else begin
        r.kind = KIND_HIT_DROP;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      codes.event_header = RESET_CODE_EVENT_HEADER;
      codes.trigger_time = RESET_CODE_TRIGGER_TIME;
      codes.device_id = RESET_CODE_DEVICE_ID;
      codes.tdc_hit = RESET_CODE_TDC_HIT;
      cur_type = '0;
      type_known = 1'b0;
      cont_idx = 2'd0;
      ticks = '0;
      fiber = '0;
      slot = '0;
      hit_count = 0;
      event_open = 1'b0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CODE_EVENT_HEADER: codes.event_header = cfg_data;
          REG_CODE_TRIGGER_TIME: codes.trigger_time = cfg_data;
          REG_CODE_DEVICE_ID:    codes.device_id = cfg_data;
          REG_CODE_TDC_HIT:      codes.tdc_hit = cfg_data;
          default: ;
        endcase
      end
      // pop before push so a beat never meets its own expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("out beat with nothing expected: kind 0x%0h", kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind));
          check_field("hit_channel", 64'(want.hit_channel), 64'(hit_channel));
          check_field("hit_edge", 64'(want.hit_edge), 64'(hit_edge));
          check_field("hit_fiber", 64'(want.hit_fiber), 64'(hit_fiber));
          check_field("hit_slot", 64'(want.hit_slot), 64'(hit_slot));
          check_field("hit_time", 64'(want.hit_time), 64'(hit_time));
          check_field("hit_index", 64'(want.hit_index), 64'(hit_index));
          check_field("trigger_number", 64'(want.trigger_number), 64'(trigger_number));
          check_field("trigger_ticks", 64'(want.trigger_ticks), 64'(trigger_ticks));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(decode_word(word, first_word));
    end
    pending = expected_results.size();
  end

endmodule

### test/tagged_word_tdc_decoder_tb.sv
module tagged_word_tdc_decoder_tb;
  import twd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 300;
  localparam int NUM_PHASES  = 6;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [31:0]          word;
  logic                 first_word;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_W-1:0]    kind;
  logic [7:0]           hit_channel;
  logic                 hit_edge;
  logic [4:0]           hit_fiber;
  logic [4:0]           hit_slot;
  logic [14:0]          hit_time;
  logic [8:0]           hit_index;
  logic [21:0]          trigger_number;
  logic [TICKS_W-1:0]   trigger_ticks;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CODE_W-1:0]    cfg_data;
  int                   mismatches;
  int                   pending;

  codes_t codes;
  int     items_sent;
  bit     in_calm;
  int     idle_cycles;

  tagged_word_tdc_decoder u_dut (.*);

  tdc_decode_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_beat(input logic [31:0] w, input logic first);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    first_word <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_codes(input codes_t c);
    cfg_we <= 1'b1;
    cfg_index <= REG_CODE_EVENT_HEADER;
    cfg_data <= c.event_header;
    @(negedge clk);
    cfg_index <= REG_CODE_TRIGGER_TIME;
    cfg_data <= c.trigger_time;
    @(negedge clk);
    cfg_index <= REG_CODE_DEVICE_ID;
    cfg_data <= c.device_id;
    @(negedge clk);
    cfg_index <= REG_CODE_TDC_HIT;
    cfg_data <= c.tdc_hit;
    @(negedge clk);
    cfg_we <= 1'b0;
    codes = c;
  endtask

  task automatic run_event(input bit long_hits);
    logic [CODE_W-1:0] c;
    int                groups;
    int                conts;
    int                sel;
    if ($urandom_range(0, 5) == 0) in_calm = !in_calm;
    if (!long_hits && $urandom_range(0, 11) == 0) send_beat($urandom, 1'b1);
    else send_beat({1'b1, codes.event_header, 27'($urandom)}, 1'b1);
    // continuation before any type word
    if ($urandom_range(0, 4) == 0) send_beat({1'b0, 31'($urandom)}, 1'b0);
    groups = $urandom_range(1, 6);
    repeat (groups) begin
      sel = $urandom_range(0, 11);
      conts = $urandom_range(0, 3);
      case (sel)
        0: c = codes.event_header;
        1, 2: c = codes.trigger_time;
        3: c = codes.device_id;
        4, 5, 6, 7: begin
          c = codes.tdc_hit;
          conts = $urandom_range(0, 8);
        end
        8: begin
          do c = 4'($urandom);
          while (c == codes.event_header || c == codes.trigger_time ||
                 c == codes.device_id || c == codes.tdc_hit);
        end
        default: c = 4'($urandom);
      endcase
      send_beat({1'b1, c, 27'($urandom)}, 1'b0);
      repeat (conts) send_beat({1'b0, 31'($urandom)}, 1'b0);
    end
    // run past hit capacity
    if (long_hits) begin
      send_beat({1'b1, codes.tdc_hit, 27'($urandom)}, 1'b0);
      repeat ($urandom_range(258, 266)) send_beat({1'b0, 31'($urandom)}, 1'b0);
    end
  endtask

  initial begin
    codes_t next;
    int     budget;
    rst = 1'b1;
    in_valid = 1'b0;
    word = '0;
    first_word = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CODE_EVENT_HEADER;
    cfg_data = '0;
    items_sent = 0;
    in_calm = 1'b0;
    budget = 0;
    codes.event_header = RESET_CODE_EVENT_HEADER;
    codes.trigger_time = RESET_CODE_TRIGGER_TIME;
    codes.device_id = RESET_CODE_DEVICE_ID;
    codes.tdc_hit = RESET_CODE_TDC_HIT;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // outside any event, then bad headers and a word after one
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat({1'b0, RESET_CODE_EVENT_HEADER, 27'h7FF_FFFF}, 1'b1);
    send_beat({1'b1, RESET_CODE_TDC_HIT, 27'h123_4567}, 1'b0);
    send_beat({1'b1, RESET_CODE_TRIGGER_TIME, 27'h0}, 1'b1);
    send_beat({1'b1, RESET_CODE_EVENT_HEADER, 5'd31, 22'h3F_FFFF}, 1'b1);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat({1'b1, RESET_CODE_EVENT_HEADER, 5'd0, 22'h3F_FFFF}, 1'b0);
    send_beat(32'h0, 1'b0);
    // trigger time: low half, high half, then saturated index
    send_beat({1'b1, RESET_CODE_TRIGGER_TIME, 3'd0, 24'hFF_FFFF}, 1'b0);
    send_beat({1'b0, 7'h7F, 24'hAB_CDEF}, 1'b0);
    send_beat({1'b0, 7'h00, 24'h12_3456}, 1'b0);
    send_beat({1'b0, 7'h55, 24'hFF_FFFF}, 1'b0);
    send_beat({1'b1, RESET_CODE_DEVICE_ID, 5'd31, 22'h0}, 1'b0);
    send_beat({1'b1, RESET_CODE_TDC_HIT, 1'b1, 2'b11, 8'hFF, 1'b1, 15'h7FFF}, 1'b0);
    send_beat({1'b0, 4'h0, 1'b0, 2'b00, 8'h00, 1'b0, 15'h0000}, 1'b0);
    send_beat({1'b1, RESET_CODE_DEVICE_ID, 5'd0, 22'h3F_FFFF}, 1'b0);
    send_beat({1'b0, 4'hF, 5'd10, 22'h0}, 1'b0);
    send_beat({1'b1, RESET_CODE_TDC_HIT, 27'h0}, 1'b0);
    send_beat({1'b1, 4'hF, 27'h7FF_FFFF}, 1'b0);
    send_beat(32'h1234_5678, 1'b0);
    // fiber survives into the next event
    send_beat({1'b1, RESET_CODE_EVENT_HEADER, 27'h0}, 1'b1);
    send_beat({1'b1, RESET_CODE_TDC_HIT, 27'h555_5555}, 1'b0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          next.event_header = RESET_CODE_EVENT_HEADER;
          next.trigger_time = RESET_CODE_TRIGGER_TIME;
          next.device_id = RESET_CODE_DEVICE_ID;
          next.tdc_hit = RESET_CODE_TDC_HIT;
        end
        1: next = '0;
        2: next = '1;
        3: begin
          next.event_header = 4'd15;
          next.trigger_time = 4'd0;
          next.device_id = 4'd14;
          next.tdc_hit = 4'd1;
        end
        4: begin
          // shared codes: header beats trigger time, device id beats tdc
          next.event_header = 4'd6;
          next.trigger_time = 4'd6;
          next.device_id = 4'd11;
          next.tdc_hit = 4'd11;
        end
        default: next = codes_t'(16'($urandom));
      endcase
      set_codes(next);
      budget += PHASE_ITEMS;
      run_event(phase == 0 || phase == 3);
      while (items_sent < budget) run_event(1'b0);
    end
    drain();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int stall;
    bit out_calm;
    out_ready = 1'b0;
    out_calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

### sim.f
sv/twd_pkg.sv
sv/twd_decode.sv
sv/tagged_word_tdc_decoder.sv
test/tdc_decode_checker.sv
test/tagged_word_tdc_decoder_tb.sv
